@@ src/ptt_pkg.sv @@
// shared types and codes for the partitioned edf task table
package ptt_pkg;

  typedef enum logic [1:0] {
    MODE_ADD    = 2'd0,
    MODE_REMOVE = 2'd1,
    MODE_LOCATE = 2'd2,
    MODE_PICK   = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_FULL       = 3'd1,
    ST_NOT_FOUND  = 3'd2,
    ST_WRONG_CORE = 3'd3,
    ST_RUNNING    = 3'd4,
    ST_NULL_ID    = 3'd5
  } status_t;

  localparam logic [7:0]  NULL_ID     = 8'd0;
  localparam logic [31:0] NO_DEADLINE = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [7:0]  task_id;
    logic [31:0] release_tick;
    logic [31:0] deadline_tick;
  } entry_t;

  typedef struct packed {
    mode_t       mode;
    logic        core;
    logic        periodic;
    logic [7:0]  task_id;
    logic [31:0] release_tick;
    logic [31:0] deadline_tick;
    logic [31:0] now_tick;
    logic [7:0]  running_id;
  } req_t;

  typedef struct packed {
    logic clear;
    logic valid;
    logic pick;
    logic aperiodic;
  } eval_ctrl_t;

  typedef struct packed {
    logic        match;
    logic [7:0]  chosen_id;
    logic [31:0] chosen_deadline;
  } eval_out_t;

endpackage

@@ src/ptt_req_if.sv @@
// request channel: one table operation per beat
interface ptt_req_if;
  import ptt_pkg::*;

  logic        valid;
  logic        ready;
  mode_t       mode;
  logic        core;
  logic        periodic;
  logic [7:0]  task_id;
  logic [31:0] release_tick;
  logic [31:0] deadline_tick;
  logic [31:0] now_tick;
  logic [7:0]  running_id;

  modport source (
    output valid, mode, core, periodic, task_id, release_tick, deadline_tick,
           now_tick, running_id,
    input  ready
  );

  modport sink (
    input  valid, mode, core, periodic, task_id, release_tick, deadline_tick,
           now_tick, running_id,
    output ready
  );
endinterface

@@ src/ptt_res_if.sv @@
// result channel: one status beat per request
interface ptt_res_if;
  import ptt_pkg::*;

  logic        valid;
  logic        ready;
  status_t     status;
  logic        found_core;
  logic        found_periodic;
  logic [7:0]  chosen_id;
  logic [31:0] chosen_deadline;

  modport source (
    output valid, status, found_core, found_periodic, chosen_id, chosen_deadline,
    input  ready
  );

  modport sink (
    input  valid, status, found_core, found_periodic, chosen_id, chosen_deadline,
    output ready
  );
endinterface

@@ src/ptt_entry_ram.sv @@
// task entry memory, one write port and one registered read port
module ptt_entry_ram #(
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  ptt_pkg::entry_t          wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output ptt_pkg::entry_t          rdata
);
  import ptt_pkg::*;

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ src/ptt_eval_unit.sv @@
// shared compare unit: id match, release check and running deadline minimum
module ptt_eval_unit (
  input  logic                clk,
  input  ptt_pkg::eval_ctrl_t ctrl,
  input  ptt_pkg::entry_t     rdata,
  input  logic [7:0]          task_id,
  input  logic [31:0]         now_tick,
  output ptt_pkg::eval_out_t  result
);
  import ptt_pkg::*;

  logic [31:0] p_dl;
  logic [31:0] a_dl;
  logic [7:0]  p_id;
  logic [7:0]  a_id;
  logic [31:0] sel_dl;
  logic        eligible;
  logic        better;
  logic        take_p;

  assign eligible = !(now_tick < rdata.release_tick);
  assign sel_dl   = ctrl.aperiodic ? a_dl : p_dl;
  assign better   = rdata.deadline_tick < sel_dl;
  assign take_p   = p_dl < a_dl;

  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      p_dl <= NO_DEADLINE;
      a_dl <= NO_DEADLINE;
      p_id <= NULL_ID;
      a_id <= NULL_ID;
    end else if (ctrl.valid && ctrl.pick && eligible && better) begin
      if (ctrl.aperiodic) begin
        a_dl <= rdata.deadline_tick;
        a_id <= rdata.task_id;
      end else begin
        p_dl <= rdata.deadline_tick;
        p_id <= rdata.task_id;
      end
    end
  end

  // aperiodic wins ties
  always_comb begin
    result.match           = ctrl.valid && !ctrl.pick && (rdata.task_id == task_id);
    result.chosen_id       = take_p ? p_id : a_id;
    result.chosen_deadline = take_p ? p_dl : a_dl;
  end
endmodule

@@ src/partitioned_edf_task_table_unit.sv @@
// partitioned edf task table: per-core periodic and aperiodic task lists
//
// A request beat on req carries one operation: add, remove, locate or pick.
// Every request yields exactly one beat on res, in request order.
// The block takes one request at a time; req.ready is high only while idle.
// Entries live in one memory, read one entry per cycle by the scan sequencer
// and checked by a single compare unit (id match, release test, deadline min).
// Path from accept to result valid:
//   add, or any request refused on its core or id: straight to the result
//   pick: scans every entry in the core's two tables
//   locate / remove: scan the tables in order up to the first match,
//   a remove that succeeds then reads the last entry and moves it into the hole.
// req.ready returns the cycle after the result loads.
// Reset empties every table (counts go to zero) and drops any pending beat.
// A stalled res beat holds; the result register frees the sequencer, but the
// next request is taken only after its beat is loaded into the register.
module partitioned_edf_task_table_unit #(
  parameter int NUM_CORES       = 2,
  parameter int PERIODIC_SLOTS  = 8,
  parameter int APERIODIC_SLOTS = 8
) (
  input  logic   clk,
  input  logic   rst,
  ptt_req_if.sink   req,
  ptt_res_if.source res
);
  import ptt_pkg::*;

  localparam int NT     = 2 * NUM_CORES;
  localparam int TW     = $clog2(NT);
  localparam int SPAN   = PERIODIC_SLOTS + APERIODIC_SLOTS;
  localparam int DEPTH  = NUM_CORES * SPAN;
  localparam int AW     = $clog2(DEPTH);
  localparam int MAXCAP = (PERIODIC_SLOTS > APERIODIC_SLOTS) ? PERIODIC_SLOTS
                                                              : APERIODIC_SLOTS;
  localparam int CW     = $clog2(MAXCAP + 1);

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_START   = 6'b000010,
    S_SCAN    = 6'b000100,
    S_LAST_RD = 6'b001000,
    S_LAST_WR = 6'b010000,
    S_DONE    = 6'b100000
  } state_t;

  function automatic logic [AW-1:0] base_of(input logic [TW-1:0] t);
    int b;
    b = int'(t >> 1) * SPAN + (t[0] ? PERIODIC_SLOTS : 0);
    return AW'(b);
  endfunction

  function automatic logic [CW-1:0] cap_of(input logic [TW-1:0] t);
    return t[0] ? CW'(APERIODIC_SLOTS) : CW'(PERIODIC_SLOTS);
  endfunction

  state_t        state;
  req_t          rq;
  logic [CW-1:0] counts [NT];
  logic [TW-1:0] cur_tbl;
  logic [TW-1:0] last_tbl;
  logic [TW-1:0] rd_tbl;
  logic [TW-1:0] f_tbl;
  logic [CW-1:0] cur_slot;
  logic [CW-1:0] rd_slot;
  logic [CW-1:0] f_slot;
  logic          issue_done;
  logic          rd_vld;
  status_t       res_status;
  logic          res_fcore;
  logic          res_fper;
  logic          out_valid;

  logic          core_ok;
  logic [TW-1:0] add_tbl;
  logic [TW-1:0] pick_tbl;
  logic [TW-1:0] rd_core;
  logic          add_ok;
  logic          slot_hit;
  logic          issue;
  logic          pick_ok;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [AW-1:0] mem_raddr;
  entry_t        mem_wdata;
  entry_t        mem_rdata;

  eval_ctrl_t    ev_ctrl;
  eval_out_t     ev_out;

  assign core_ok  = int'(rq.core) < NUM_CORES;
  assign add_tbl  = TW'(2 * int'(rq.core) + (rq.periodic ? 0 : 1));
  assign pick_tbl = TW'(2 * int'(rq.core));
  assign rd_core  = rd_tbl >> 1;
  assign add_ok   = core_ok && (rq.task_id != NULL_ID) &&
                    (counts[add_tbl] < cap_of(add_tbl));
  assign slot_hit = cur_slot < counts[cur_tbl];
  assign issue    = (state == S_SCAN) && !issue_done && slot_hit;
  assign pick_ok  = (rq.mode == MODE_PICK) && (res_status == ST_OK);

  assign req.ready = (state == S_IDLE) && !rst;
  assign res.valid = out_valid;

  always_comb begin
    mem_raddr = (state == S_LAST_RD) ? base_of(f_tbl) + AW'(counts[f_tbl] - CW'(1))
                                     : base_of(cur_tbl) + AW'(cur_slot);
    mem_we    = ((state == S_START) && (rq.mode == MODE_ADD) && add_ok) ||
                (state == S_LAST_WR);
    if (state == S_LAST_WR) begin
      mem_waddr = base_of(f_tbl) + AW'(f_slot);
      mem_wdata = mem_rdata;
    end else begin
      mem_waddr = base_of(add_tbl) + AW'(counts[add_tbl]);
      mem_wdata = '{task_id: rq.task_id, release_tick: rq.release_tick,
                    deadline_tick: rq.deadline_tick};
    end
  end

  always_comb begin
    ev_ctrl.clear     = (state == S_START);
    ev_ctrl.valid     = rd_vld && (state == S_SCAN);
    ev_ctrl.pick      = (rq.mode == MODE_PICK);
    ev_ctrl.aperiodic = rd_tbl[0];
  end

  ptt_entry_ram #(.DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  ptt_eval_unit u_eval (
    .clk      (clk),
    .ctrl     (ev_ctrl),
    .rdata    (mem_rdata),
    .task_id  (rq.task_id),
    .now_tick (rq.now_tick),
    .result   (ev_out)
  );

  always_ff @(posedge clk) begin
    rd_tbl  <= cur_tbl;
    rd_slot <= cur_slot;
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      rd_vld     <= 1'b0;
      issue_done <= 1'b0;
      for (int i = 0; i < NT; i++) begin
        counts[i] <= '0;
      end
    end else begin
      rd_vld <= issue;
      if (out_valid && res.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req.valid && req.ready) begin
            rq.mode          <= req.mode;
            rq.core          <= req.core;
            rq.periodic      <= req.periodic;
            rq.task_id       <= req.task_id;
            rq.release_tick  <= req.release_tick;
            rq.deadline_tick <= req.deadline_tick;
            rq.now_tick      <= req.now_tick;
            rq.running_id    <= req.running_id;
            state            <= S_START;
          end
        end
        S_START: begin
          res_status <= ST_OK;
          res_fcore  <= 1'b0;
          res_fper   <= 1'b0;
          cur_slot   <= '0;
          issue_done <= 1'b0;
          cur_tbl    <= '0;
          last_tbl   <= TW'(NT - 1);
          state      <= S_DONE;
          unique case (rq.mode)
            MODE_ADD: begin
              if (!core_ok) begin
                res_status <= ST_WRONG_CORE;
              end else if (rq.task_id == NULL_ID) begin
                res_status <= ST_NULL_ID;
              end else if (!add_ok) begin
                res_status <= ST_FULL;
              end else begin
                counts[add_tbl] <= counts[add_tbl] + CW'(1);
              end
            end
            MODE_REMOVE: begin
              if (!core_ok) begin
                res_status <= ST_WRONG_CORE;
              end else if (rq.task_id == NULL_ID) begin
                res_status <= ST_NULL_ID;
              end else begin
                state <= S_SCAN;
              end
            end
            MODE_LOCATE: begin
              if (rq.task_id == NULL_ID) begin
                res_status <= ST_NULL_ID;
              end else begin
                state <= S_SCAN;
              end
            end
            MODE_PICK: begin
              if (!core_ok) begin
                res_status <= ST_WRONG_CORE;
              end else begin
                cur_tbl  <= pick_tbl;
                last_tbl <= pick_tbl + TW'(1);
                state    <= S_SCAN;
              end
            end
            default: state <= S_DONE;
          endcase
        end
        S_SCAN: begin
          if (!issue_done) begin
            if (slot_hit) begin
              cur_slot <= cur_slot + CW'(1);
            end else if (cur_tbl == last_tbl) begin
              issue_done <= 1'b1;
            end else begin
              cur_tbl  <= cur_tbl + TW'(1);
              cur_slot <= '0;
            end
          end
          if (ev_out.match) begin
            if (rq.mode == MODE_LOCATE) begin
              res_fcore <= rd_core[0];
              res_fper  <= ~rd_tbl[0];
              state     <= S_DONE;
            end else if (int'(rd_core) != int'(rq.core)) begin
              res_status <= ST_WRONG_CORE;
              state      <= S_DONE;
            end else if (rq.task_id == rq.running_id) begin
              res_status <= ST_RUNNING;
              state      <= S_DONE;
            end else begin
              f_tbl  <= rd_tbl;
              f_slot <= rd_slot;
              state  <= S_LAST_RD;
            end
          end else if (issue_done && !rd_vld) begin
            if (rq.mode != MODE_PICK) begin
              res_status <= ST_NOT_FOUND;
            end
            state <= S_DONE;
          end
        end
        S_LAST_RD: begin
          state <= S_LAST_WR;
        end
        S_LAST_WR: begin
          counts[f_tbl] <= counts[f_tbl] - CW'(1);
          state         <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || res.ready) begin
            out_valid           <= 1'b1;
            res.status          <= res_status;
            res.found_core      <= res_fcore;
            res.found_periodic  <= res_fper;
            res.chosen_id       <= pick_ok ? ev_out.chosen_id : NULL_ID;
            res.chosen_deadline <= pick_ok ? ev_out.chosen_deadline : NO_DEADLINE;
            state               <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

@@ src/ptt_checker.sv @@
// port-level assertions for the partitioned edf task table, bound to the top
module ptt_checker (
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_ready,
  input logic        res_valid,
  input logic        res_ready,
  input logic [2:0]  status,
  input logic        found_core,
  input logic        found_periodic,
  input logic [7:0]  chosen_id,
  input logic [31:0] chosen_deadline
);
  import ptt_pkg::*;

  a_reset_clears: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result beat pending after reset");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !req_ready)
    else $error("request taken while previous one in progress");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |=> (res_valid && $stable(status) &&
                                   $stable(chosen_id) && $stable(chosen_deadline)))
    else $error("stalled result beat changed");

  a_none_pairs: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> ((chosen_id == NULL_ID) == (chosen_deadline == NO_DEADLINE)))
    else $error("chosen id and deadline disagree");

  a_fail_clean: assert property (@(posedge clk) disable iff (rst)
    (res_valid && (status != ST_OK)) |->
      ((chosen_id == NULL_ID) && !found_core && !found_periodic))
    else $error("failed request carries location or choice");
endmodule

bind partitioned_edf_task_table_unit ptt_checker u_ptt_checker (
  .clk             (clk),
  .rst             (rst),
  .req_valid       (req.valid),
  .req_ready       (req.ready),
  .res_valid       (res.valid),
  .res_ready       (res.ready),
  .status          (res.status),
  .found_core      (res.found_core),
  .found_periodic  (res.found_periodic),
  .chosen_id       (res.chosen_id),
  .chosen_deadline (res.chosen_deadline)
);
